// ----- hw/rtl/tlw_pkg.sv -----
// Shared types and constants of the text line width measure block.
package tlw_pkg;

   localparam int CODE_W   = 7;
   localparam int METRIC_W = 8;
   localparam int OUT_W    = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int SKIP_W   = 4;
   // Width plus kerning needs 10 signed bits, and a left shift adds up to 7.
   localparam int ADV_W    = 17;

   localparam logic [CODE_W-1:0]  CODE_NEWLINE = 7'd10;
   localparam logic [CODE_W-1:0]  CODE_SPACE   = 7'd32;
   localparam logic [CODE_W-1:0]  CODE_COLOR   = 7'd35;
   localparam logic [SKIP_W-1:0]  COLOR_SKIP   = 4'd8;
   localparam logic [OUT_W-1:0]   OUT_MAX      = 24'hFFFFFF;

   localparam logic [7:0] SPACE_WIDTH_RST = 8'd4;
   localparam logic [3:0] SCALE_SHIFT_RST = 4'd0;

   typedef enum logic {
      KIND_LOAD    = 1'b0,
      KIND_MEASURE = 1'b1
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPACE_WIDTH = 2'd0,
      CSR_SCALE_SHIFT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [METRIC_W-1:0] kerning;
      logic [METRIC_W-1:0] width;
   } glyph_type;

   typedef struct packed {
      logic [7:0] space_width;
      logic [3:0] scale_shift;
   } cfg_type;

   typedef struct packed {
      logic [CODE_W-1:0] char_code;
      logic              last;
   } meas_type;

endpackage

// ----- hw/rtl/tlw_ifs.sv -----
// Channel interfaces of the text line width measure block.
interface tlw_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic [tlw_pkg::CODE_W-1:0]           char_code;
   logic [tlw_pkg::METRIC_W-1:0]         glyph_width;
   logic signed [tlw_pkg::METRIC_W-1:0]  glyph_kerning;
   logic                                 last;

   modport source (output valid, kind, char_code, glyph_width, glyph_kerning, last,
                   input ready);
   modport sink (input valid, kind, char_code, glyph_width, glyph_kerning, last,
                 output ready);
endinterface

interface tlw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tlw_pkg::OUT_W-1:0]   max_width;

   modport source (output valid, max_width, input ready);
   modport sink (input valid, max_width, output ready);
endinterface

interface tlw_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tlw_pkg::CSR_IDX_W-1:0]    index;
   logic [tlw_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/tlw_ram.sv -----
// Generic single write port RAM with a registered read port.
module tlw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/tlw_glyph_table.sv -----
// Glyph metric table: RAM plus per-entry valid bits so unwritten entries read as zero.
module tlw_glyph_table #(
   parameter int GLYPH_COUNT = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [tlw_pkg::CODE_W-1:0]    wr_code,
   input  tlw_pkg::glyph_type            wr_glyph,
   input  logic                          rd_en,
   input  logic [tlw_pkg::CODE_W-1:0]    rd_code,
   output tlw_pkg::glyph_type            rd_glyph
);

   localparam int ADDR_W = $clog2(GLYPH_COUNT);

   logic [GLYPH_COUNT-1:0] valid_ff;
   logic [GLYPH_COUNT-1:0] valid_in;
   logic                   hit_ff;
   logic                   hit_in;
   logic                   wr_in_range;
   logic                   rd_in_range;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [15:0]            ram_q;

   assign wr_in_range = (int'(wr_code) < GLYPH_COUNT);
   assign rd_in_range = (int'(rd_code) < GLYPH_COUNT);
   assign wr_addr     = ADDR_W'(wr_code);
   assign rd_addr     = ADDR_W'(rd_code);

   always_comb begin
      valid_in = valid_ff;
      if (wr_en && wr_in_range) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // Codes beyond the table and entries never loaded read as zero metrics.
   assign hit_in = rd_in_range && valid_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            hit_ff <= hit_in;
         end
      end
   end

   tlw_ram #(
      .WIDTH (16),
      .DEPTH (GLYPH_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en && wr_in_range),
      .wr_addr (wr_addr),
      .wr_data (wr_glyph),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rd_glyph = hit_ff ? tlw_pkg::glyph_type'(ram_q) : '0;

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (wr_en && wr_in_range) |=> valid_ff[$past(wr_addr)])
      else $error("glyph entry not marked valid after load");

endmodule

// ----- hw/rtl/tlw_row_accum.sv -----
// Row accumulator: scales advances, tracks row sum and widest row, holds the result register.
module tlw_row_accum #(
   parameter int SUM_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tlw_pkg::cfg_type             cfg,
   input  logic                         item_valid,
   input  tlw_pkg::meas_type            item,
   input  tlw_pkg::glyph_type           glyph,
   output logic                         item_go,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tlw_pkg::OUT_W-1:0]    rsp_max_width
);

   localparam int SW     = SUM_BITS + 2;
   localparam int WIDE_W = (SUM_BITS > tlw_pkg::OUT_W) ? SUM_BITS : tlw_pkg::OUT_W;
   localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< SUM_BITS) - 64'sd1);
   localparam logic signed [SW-1:0] SAT_LO = SW'(-(64'sd1 <<< SUM_BITS));

   logic signed [SUM_BITS:0]          row_sum_ff, row_sum_in;
   logic [SUM_BITS-1:0]               best_ff, best_in;
   logic [tlw_pkg::SKIP_W-1:0]        skip_ff, skip_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [tlw_pkg::OUT_W-1:0]         max_width_ff, max_width_in;

   logic signed [9:0]                 glyph_adv;
   logic signed [tlw_pkg::ADV_W-1:0]  raw_adv;
   logic signed [tlw_pkg::ADV_W-1:0]  adv;
   logic [3:0]                        shr;
   logic signed [SW-1:0]              sum;
   logic signed [SW-1:0]              sat;
   logic signed [SUM_BITS:0]          row_n;
   logic [SUM_BITS-1:0]               best_n;
   logic [tlw_pkg::SKIP_W-1:0]        skip_n;
   logic [SUM_BITS-1:0]               widest;
   logic [WIDE_W-1:0]                 widest_ext;
   logic                              is_space;

   assign item_go = item_valid && (!item.last || !rsp_valid_ff || rsp_ready);

   assign is_space  = (item.char_code == tlw_pkg::CODE_SPACE);
   assign glyph_adv = $signed({{2{glyph.kerning[7]}}, glyph.kerning})
                    + $signed({2'b00, glyph.width});
   assign raw_adv   = is_space ? $signed(tlw_pkg::ADV_W'(cfg.space_width))
                               : tlw_pkg::ADV_W'(glyph_adv);
   assign shr       = 4'(~cfg.scale_shift + 4'd1);

   // Arithmetic right shift rounds toward minus infinity.
   always_comb begin
      if (!cfg.scale_shift[3]) begin
         adv = raw_adv <<< cfg.scale_shift[2:0];
      end else begin
         adv = raw_adv >>> shr;
      end
   end

   assign sum = SW'(row_sum_ff) + SW'(adv);

   always_comb begin
      if (sum > SAT_HI) begin
         sat = SAT_HI;
      end else if (sum < SAT_LO) begin
         sat = SAT_LO;
      end else begin
         sat = sum;
      end
   end

   always_comb begin
      row_n  = row_sum_ff;
      best_n = best_ff;
      skip_n = skip_ff;
      if (skip_ff != '0) begin
         skip_n = skip_ff - 4'd1;
      end else begin
         case (item.char_code)
            tlw_pkg::CODE_NEWLINE: begin
               if (row_sum_ff > $signed({1'b0, best_ff})) begin
                  best_n = SUM_BITS'(row_sum_ff);
               end
               row_n = '0;
            end
            tlw_pkg::CODE_COLOR: begin
               skip_n = tlw_pkg::COLOR_SKIP;
            end
            default: begin
               row_n = (SUM_BITS+1)'(sat);
            end
         endcase
      end
   end

   // The widest row is never negative because the best row starts at zero.
   always_comb begin
      if (row_n > $signed({1'b0, best_n})) begin
         widest = SUM_BITS'(row_n);
      end else begin
         widest = best_n;
      end
      widest_ext = WIDE_W'(widest);
      if (widest_ext > WIDE_W'(tlw_pkg::OUT_MAX)) begin
         max_width_in = tlw_pkg::OUT_MAX;
      end else begin
         max_width_in = tlw_pkg::OUT_W'(widest_ext);
      end
   end

   always_comb begin
      row_sum_in = row_sum_ff;
      best_in    = best_ff;
      skip_in    = skip_ff;
      if (item_go) begin
         if (item.last) begin
            row_sum_in = '0;
            best_in    = '0;
            skip_in    = '0;
         end else begin
            row_sum_in = row_n;
            best_in    = best_n;
            skip_in    = skip_n;
         end
      end
      if (item_go && item.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_sum_ff   <= '0;
         best_ff      <= '0;
         skip_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_sum_ff   <= row_sum_in;
         best_ff      <= best_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_go && item.last) begin
         max_width_ff <= max_width_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_width = max_width_ff;

   a_skip_bound: assert property (@(posedge clock) disable iff (reset)
      skip_ff <= tlw_pkg::COLOR_SKIP)
      else $error("color skip count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(item_go && item.last && rsp_valid_ff && !rsp_ready))
      else $error("result register overwritten while held");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (item_go && item.last) |=> (row_sum_ff == '0 && best_ff == '0 && skip_ff == '0))
      else $error("string state not cleared after last item");

endmodule

// ----- hw/rtl/text_line_width_measure.sv -----
// Top level of the text line width measure block.
//
//   channel  direction  handshake        payload
//   req_ch   in         valid / ready    kind, char_code, glyph_width, glyph_kerning, last
//   rsp_ch   out        valid / ready    max_width
//   csr_ch   in         valid / ready    index, data
//
// One item is taken per cycle while no held result stalls a last item. A load writes the glyph
// RAM at its accept edge; a measure reads the RAM at its accept edge and updates the row as it
// leaves the stage register, and the result of a last item is registered at that same edge.
// The loop that bounds the rate is the row sum update: one shift, add and saturate per cycle.
// Reset is synchronous, clears the glyph valid bits, the row state and the valid flags, and loads the config defaults.
// A held result stalls the input only when the item in flight is itself a last item.
module text_line_width_measure #(
   parameter int GLYPH_COUNT = 128,
   parameter int SUM_BITS    = 24
) (
   input logic        clock,
   input logic        reset,
   tlw_req_if.sink    req_ch,
   tlw_rsp_if.source  rsp_ch,
   tlw_csr_if.sink    csr_ch
);

   tlw_pkg::cfg_type   cfg_ff, cfg_in;
   tlw_pkg::meas_type  s1_item_ff;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_go;
   logic               accept;
   logic               accept_load;
   logic               accept_meas;
   tlw_pkg::glyph_type glyph_wr;
   tlw_pkg::glyph_type glyph_rd;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            tlw_pkg::CSR_SPACE_WIDTH: cfg_in.space_width = csr_ch.data;
            tlw_pkg::CSR_SCALE_SHIFT: cfg_in.scale_shift = csr_ch.data[3:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign accept       = req_ch.valid && req_ch.ready;
   assign accept_load  = accept && (req_ch.kind == tlw_pkg::KIND_LOAD);
   assign accept_meas  = accept && (req_ch.kind == tlw_pkg::KIND_MEASURE);

   assign glyph_wr.width   = req_ch.glyph_width;
   assign glyph_wr.kerning = req_ch.glyph_kerning;

   always_comb begin
      if (accept_meas) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.space_width <= tlw_pkg::SPACE_WIDTH_RST;
         cfg_ff.scale_shift <= tlw_pkg::SCALE_SHIFT_RST;
         s1_valid_ff        <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_meas) begin
         s1_item_ff.char_code <= req_ch.char_code;
         s1_item_ff.last      <= req_ch.last;
      end
   end

   tlw_glyph_table #(
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_glyph_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept_load),
      .wr_code  (req_ch.char_code),
      .wr_glyph (glyph_wr),
      .rd_en    (accept_meas),
      .rd_code  (req_ch.char_code),
      .rd_glyph (glyph_rd)
   );

   tlw_row_accum #(
      .SUM_BITS (SUM_BITS)
   ) u_row_accum (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .item_valid    (s1_valid_ff),
      .item          (s1_item_ff),
      .glyph         (glyph_rd),
      .item_go       (s1_go),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_max_width (rsp_ch.max_width)
   );

   a_stall_has_item: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && s1_item_ff.last && rsp_ch.valid))
      else $error("input stalled without a held last item");

endmodule
